FILE: sv/ascii_register_read_poller_top_defines.svh
// ----------------------------------------------------------------------------
// ascii register read poller assertion macros
// Concurrent assertion wrappers, compiled away for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASCII_REGISTER_READ_POLLER_TOP_DEFINES_SVH
`define ASCII_REGISTER_READ_POLLER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// check sampled on the rising clock, muted while reset is low
`define ARRP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check sampled on the rising clock at every edge
`define ARRP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ARRP_ASSERT(lbl, clk, rst_n, prop, msg)

`define ARRP_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: sv/arrp_pkg.sv
// ----------------------------------------------------------------------------
// arrp_pkg
// Codes, character constants and helpers for the ascii register read poller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package arrp_pkg;

    // item opcodes
    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_RX    = 2'd1,
        OP_TICK  = 2'd2
    } t_opcode;

    // result kinds
    typedef enum logic {
        KIND_TX   = 1'b0,
        KIND_DONE = 1'b1
    } t_kind;

    // completion status
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FRAMING = 2'd1,
        ST_TIMEOUT = 2'd2
    } t_status;

    // configuration register indexes
    typedef enum logic {
        CFG_BUFFER_WORDS  = 1'b0,
        CFG_TIMEOUT_TICKS = 1'b1
    } t_cfg_index;

    localparam int          REPLY_LEN  = 8;
    localparam int          REQ_BEATS  = 6;
    localparam int          CFG_DATA_W = 16;

    localparam logic [15:0] BUFFER_WORDS_RST  = 16'd4096;
    localparam logic [7:0]  TIMEOUT_TICKS_RST = 8'd2;

    localparam logic [7:0]  CHR_R     = 8'h52;
    localparam logic [7:0]  CHR_D     = 8'h44;
    localparam logic [7:0]  CHR_COMMA = 8'h2C;
    localparam logic [7:0]  CHR_CR    = 8'h0D;
    localparam logic [7:0]  CHR_DASH  = 8'h2D;
    localparam logic [7:0]  CHR_STAR  = 8'h2A;
    localparam logic [7:0]  CHR_ZERO  = 8'h30;

    localparam logic [15:0] DATA_MASK        = 16'hE3FF;
    localparam logic [15:0] FLAG_UNCONNECTED = 16'h1000;
    localparam logic [15:0] FLAG_STATION_ERR = 16'h0800;
    localparam logic [15:0] FLAG_TROUBLE     = 16'h0400;

    // upper-case hex character of a nibble
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return 8'h30 + {4'b0, nib};
        end else begin
            return 8'h37 + {4'b0, nib};
        end
    endfunction

    // nibble value of a hex character, anything else reads as zero
    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) begin
            return c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            return c[3:0] + 4'd9;
        end else begin
            return 4'd0;
        end
    endfunction

endpackage

`default_nettype wire

FILE: sv/ascii_register_read_poller_top.sv
// An accepted item's first result beat is registered and shows in the next cycle.
// A start item gives six request beats in order, held while the output stalls; the
// single output register is the limit, so the next item enters with the last beat.
// Byte and tick items are taken one per cycle when the output drains.
// Synchronous active-low reset idles the poller, drops any pending beat and loads
// buffer_words 4096 and timeout_ticks 2; the reply byte store is not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "ascii_register_read_poller_top_defines.svh"

// ----------------------------------------------------------------------------
// ascii_register_read_poller_top
// Sends an ascii read request, collects the eight-byte reply, decodes it and
// reports a completion with an optional buffer store, or a timeout.
// ----------------------------------------------------------------------------
module ascii_register_read_poller_top import arrp_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // item channel
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [1:0]            i_opcode,
    input  wire logic [7:0]            i_channel_address,
    input  wire logic [15:0]           i_target_word,
    input  wire logic [7:0]            i_rx_byte,
    // result channel
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic                       o_kind,
    output logic [7:0]                 o_tx_byte,
    output logic [1:0]                 o_status,
    output logic                       o_store_valid,
    output logic [15:0]                o_store_index,
    output logic [15:0]                o_store_value,
    output logic                       o_last,
    // configuration writes
    input  wire logic                  i_cfg_wen,
    input  wire logic                  i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int          CNT_W     = $clog2(REPLY_LEN);
    localparam int          BEAT_W    = $clog2(REQ_BEATS);
    localparam logic [CNT_W-1:0]  LAST_BYTE = CNT_W'(REPLY_LEN - 1);
    localparam logic [BEAT_W-1:0] BEAT_LAST = BEAT_W'(REQ_BEATS - 1);

    // configuration
    logic [15:0] r_buffer_words;
    logic [7:0]  r_timeout_ticks;

    // transaction state
    logic              r_busy,        n_busy;
    logic [CNT_W-1:0]  r_byte_count,  n_byte_count;
    logic [15:0]       r_target,      n_target;
    logic [7:0]        r_tick_count,  n_tick_count;
    logic [7:0]        r_reply [REPLY_LEN];

    // output register
    logic              r_valid,       n_valid;
    t_kind             r_kind,        n_kind;
    logic [BEAT_W-1:0] r_beat,        n_beat;
    logic [7:0]        r_hex_hi,      n_hex_hi;
    logic [7:0]        r_hex_lo,      n_hex_lo;
    t_status           r_status,      n_status;
    logic              r_store_valid, n_store_valid;
    logic [15:0]       r_store_index, n_store_index;
    logic [15:0]       r_store_value, n_store_value;

    logic        in_acc;
    logic        out_acc;
    logic [7:0]  addr_p1;
    logic [7:0]  tick_inc;
    logic        header_ok;
    logic        in_range;
    logic [15:0] decoded;

    // handshakes
    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;
    assign o_stall = r_valid && !(out_acc && o_last);

    // result channel drive
    assign o_valid       = r_valid;
    assign o_kind        = r_kind;
    assign o_status      = r_status;
    assign o_store_valid = r_store_valid;
    assign o_store_index = r_store_index;
    assign o_store_value = r_store_value;
    assign o_last        = (r_kind == KIND_DONE) || (r_beat == BEAT_LAST);

    // request byte for the current beat
    always_comb begin
        o_tx_byte = 8'h00;
        if (r_kind == KIND_TX) begin
            unique case (r_beat)
                BEAT_W'(0): o_tx_byte = CHR_R;
                BEAT_W'(1): o_tx_byte = CHR_D;
                BEAT_W'(2): o_tx_byte = CHR_COMMA;
                BEAT_W'(3): o_tx_byte = r_hex_hi;
                BEAT_W'(4): o_tx_byte = r_hex_lo;
                default:    o_tx_byte = CHR_CR;
            endcase
        end
    end

    // reply check and decode, last byte taken straight from the input
    always_comb begin
        header_ok = (r_reply[0] == CHR_R) && (r_reply[1] == CHR_D)
                 && (r_reply[2] == CHR_COMMA) && (i_rx_byte == CHR_CR);
        in_range  = r_target < r_buffer_words;
        priority if (r_reply[3] == CHR_DASH && r_reply[4] == CHR_DASH
                  && r_reply[5] == CHR_DASH && r_reply[6] == CHR_DASH) begin
            decoded = FLAG_UNCONNECTED;
        end else if (r_reply[3] == CHR_STAR && r_reply[4] == CHR_STAR
                  && r_reply[5] == CHR_STAR && r_reply[6] == CHR_STAR) begin
            decoded = FLAG_STATION_ERR;
        end else if (r_reply[5] == CHR_ZERO && r_reply[6] == CHR_ZERO) begin
            decoded = FLAG_TROUBLE;
        end else begin
            decoded = {nibble_of(r_reply[3]), nibble_of(r_reply[4]),
                       nibble_of(r_reply[5]), nibble_of(r_reply[6])} & DATA_MASK;
        end
    end

    assign addr_p1  = i_channel_address + 8'd1;
    assign tick_inc = (r_tick_count == 8'hFF) ? r_tick_count : r_tick_count + 8'd1;

    // next state for the transaction and the output register
    always_comb begin
        n_busy        = r_busy;
        n_byte_count  = r_byte_count;
        n_target      = r_target;
        n_tick_count  = r_tick_count;
        n_valid       = r_valid;
        n_kind        = r_kind;
        n_beat        = r_beat;
        n_hex_hi      = r_hex_hi;
        n_hex_lo      = r_hex_lo;
        n_status      = r_status;
        n_store_valid = r_store_valid;
        n_store_index = r_store_index;
        n_store_value = r_store_value;

        // drain the current beat
        if (out_acc) begin
            if (o_last) begin
                n_valid = 1'b0;
            end else begin
                n_beat = r_beat + BEAT_W'(1);
            end
        end

        if (in_acc) begin
            unique case (t_opcode'(i_opcode))
                OP_START: begin
                    n_busy        = 1'b1;
                    n_byte_count  = '0;
                    n_tick_count  = 8'd0;
                    n_target      = i_target_word;
                    n_valid       = 1'b1;
                    n_kind        = KIND_TX;
                    n_beat        = '0;
                    n_hex_hi      = hex_char(addr_p1[7:4]);
                    n_hex_lo      = hex_char(addr_p1[3:0]);
                    n_status      = ST_OK;
                    n_store_valid = 1'b0;
                    n_store_index = 16'd0;
                    n_store_value = 16'd0;
                end
                OP_RX: begin
                    if (r_busy) begin
                        if (r_byte_count == LAST_BYTE) begin
                            n_busy        = 1'b0;
                            n_byte_count  = '0;
                            n_valid       = 1'b1;
                            n_kind        = KIND_DONE;
                            n_beat        = '0;
                            n_status      = header_ok ? ST_OK : ST_FRAMING;
                            n_store_valid = header_ok && in_range;
                            n_store_index = r_target;
                            n_store_value = (header_ok && in_range) ? decoded : 16'd0;
                        end else begin
                            n_byte_count = r_byte_count + CNT_W'(1);
                        end
                    end
                end
                OP_TICK: begin
                    if (r_busy) begin
                        n_tick_count = tick_inc;
                        if (tick_inc >= r_timeout_ticks) begin
                            n_busy        = 1'b0;
                            n_byte_count  = '0;
                            n_valid       = 1'b1;
                            n_kind        = KIND_DONE;
                            n_beat        = '0;
                            n_status      = ST_TIMEOUT;
                            n_store_valid = 1'b0;
                            n_store_index = r_target;
                            n_store_value = 16'd0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // state and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_byte_count <= '0;
            r_target     <= 16'd0;
            r_tick_count <= 8'd0;
            r_valid      <= 1'b0;
            r_kind       <= KIND_TX;
            r_beat       <= '0;
        end else begin
            r_busy       <= n_busy;
            r_byte_count <= n_byte_count;
            r_target     <= n_target;
            r_tick_count <= n_tick_count;
            r_valid      <= n_valid;
            r_kind       <= n_kind;
            r_beat       <= n_beat;
        end
        r_hex_hi      <= n_hex_hi;
        r_hex_lo      <= n_hex_lo;
        r_status      <= n_status;
        r_store_valid <= n_store_valid;
        r_store_index <= n_store_index;
        r_store_value <= n_store_value;
    end

    // reply byte store
    always_ff @(posedge i_clk) begin
        if (in_acc && t_opcode'(i_opcode) == OP_RX && r_busy) begin
            r_reply[r_byte_count] <= i_rx_byte;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_words  <= BUFFER_WORDS_RST;
            r_timeout_ticks <= TIMEOUT_TICKS_RST;
        end else if (i_cfg_wen) begin
            unique case (t_cfg_index'(i_cfg_addr))
                CFG_BUFFER_WORDS:  r_buffer_words  <= i_cfg_wdata[15:0];
                CFG_TIMEOUT_TICKS: r_timeout_ticks <= i_cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // checks
    `ARRP_ASSERT_ALWAYS(a_stall_needs_beat, i_clk, !r_valid |-> !o_stall, "stall without a pending beat")
    `ARRP_ASSERT(a_beat_range, i_clk, i_rst_n, r_valid && r_kind == KIND_TX |-> r_beat <= BEAT_LAST, "request beat out of range")
    `ARRP_ASSERT(a_start_first_beat, i_clk, i_rst_n, in_acc && i_opcode == OP_START |=> o_valid && o_kind == KIND_TX && o_tx_byte == CHR_R, "start did not open a request")
    `ARRP_ASSERT(a_idle_byte_silent, i_clk, i_rst_n, in_acc && i_opcode == OP_RX && !r_busy |=> !o_valid, "byte while idle gave a result")

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ascii register read poller. A queue of start,
// reply-byte and tick items feeds a valid/stall driver; every accepted item
// runs through a cycle-free poller model that queues the request and
// completion beats it should cause, and a monitor checks each result beat
// field by field. The run steps through several buffer size and timeout
// settings, written while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
    import arrp_pkg::*;

    localparam int          CYCLE_LIMIT  = 400_000;
    localparam int          DRAIN_CYCLES = 8;
    localparam logic [1:0]  OP_UNUSED    = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  addr;
        logic [15:0] target;
        logic [7:0]  rx;
    } t_poll_item;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  tx;
        t_status     status;
        logic        store_valid;
        logic [15:0] store_index;
        logic [15:0] store_value;
        logic        last;
    } t_beat;

    // dut ports
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [1:0]            i_opcode = '0;
    logic [7:0]            i_channel_address = '0;
    logic [15:0]           i_target_word = '0;
    logic [7:0]            i_rx_byte = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic                  o_kind;
    logic [7:0]            o_tx_byte;
    logic [1:0]            o_status;
    logic                  o_store_valid;
    logic [15:0]           o_store_index;
    logic [15:0]           o_store_value;
    logic                  o_last;
    logic                  i_cfg_wen = 1'b0;
    t_cfg_index            i_cfg_addr = CFG_BUFFER_WORDS;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    // bench state
    t_poll_item  pending_items[$];
    t_beat       expected_beats[$];
    int          mismatches = 0;
    int          cycles = 0;
    int          send_gap = 0;
    int          recv_gap = 0;
    logic        idle_on = 1'b1;
    logic        quiet = 1'b0;

    // poller model state and its copy of the registers
    logic        pr_busy = 1'b0;
    int          pr_count = 0;
    logic [7:0]  pr_reply [REPLY_LEN];
    logic [15:0] pr_target = '0;
    logic [7:0]  pr_ticks = '0;
    logic [15:0] cfg_buf_words = BUFFER_WORDS_RST;
    logic [7:0]  cfg_timeout = TIMEOUT_TICKS_RST;

    ascii_register_read_poller_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_opcode          (i_opcode),
        .i_channel_address (i_channel_address),
        .i_target_word     (i_target_word),
        .i_rx_byte         (i_rx_byte),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_kind            (o_kind),
        .o_tx_byte         (o_tx_byte),
        .o_status          (o_status),
        .o_store_valid     (o_store_valid),
        .o_store_index     (o_store_index),
        .o_store_value     (o_store_value),
        .o_last            (o_last),
        .i_cfg_wen         (i_cfg_wen),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_wdata       (i_cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    // upper-case hex digit for the request address
    function automatic logic [7:0] to_hex(input logic [3:0] nib);
        return (nib < 4'd10) ? CHR_ZERO + 8'(nib) : "A" + 8'(nib - 4'd10);
    endfunction

    // hex parse of one data character, non-hex reads as zero
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") return 4'(c - "0");
        if (c >= "A" && c <= "F") return 4'(c - "A" + 8'd10);
        if (c >= "a" && c <= "f") return 4'(c - "a" + 8'd10);
        return 4'd0;
    endfunction

    // poller model: one accepted item in, its result beats queued
    function automatic void poller_predict(input logic [1:0] op, input logic [7:0] addr,
                                           input logic [15:0] tgt, input logic [7:0] rxb);
        logic [7:0]  chan;
        logic [7:0]  req [REQ_BEATS];
        logic [31:0] data_chars;
        t_beat       b;
        b = '0;
        b.kind = KIND_DONE;
        b.status = ST_OK;
        b.last = 1'b1;
        case (op)
            OP_START: begin
                chan = addr + 8'd1;
                req[0] = CHR_R;
                req[1] = CHR_D;
                req[2] = CHR_COMMA;
                req[3] = to_hex(chan[7:4]);
                req[4] = to_hex(chan[3:0]);
                req[5] = CHR_CR;
                pr_target = tgt;
                pr_busy = 1'b1;
                pr_count = 0;
                pr_ticks = '0;
                b.kind = KIND_TX;
                for (int k = 0; k < REQ_BEATS; k++) begin
                    b.tx = req[k];
                    b.last = (k == REQ_BEATS - 1);
                    expected_beats.push_back(b);
                end
            end
            OP_RX: begin
                if (pr_busy) begin
                    pr_reply[pr_count] = rxb;
                    pr_count++;
                    if (pr_count == REPLY_LEN) begin
                        pr_busy = 1'b0;
                        pr_count = 0;
                        b.store_index = pr_target;
                        data_chars = {pr_reply[3], pr_reply[4], pr_reply[5], pr_reply[6]};
                        if (pr_reply[0] != CHR_R || pr_reply[1] != CHR_D ||
                            pr_reply[2] != CHR_COMMA || pr_reply[7] != CHR_CR) begin
                            b.status = ST_FRAMING;
                        end else if (pr_target < cfg_buf_words) begin
                            b.store_valid = 1'b1;
                            if (data_chars == {4{CHR_DASH}}) begin
                                b.store_value = FLAG_UNCONNECTED;
                            end else if (data_chars == {4{CHR_STAR}}) begin
                                b.store_value = FLAG_STATION_ERR;
                            end else if (pr_reply[5] == CHR_ZERO && pr_reply[6] == CHR_ZERO) begin
                                b.store_value = FLAG_TROUBLE;
                            end else begin
                                b.store_value = {hex_value(pr_reply[3]), hex_value(pr_reply[4]),
                                                 hex_value(pr_reply[5]), hex_value(pr_reply[6])}
                                                & DATA_MASK;
                            end
                        end
                        expected_beats.push_back(b);
                    end
                end
            end
            OP_TICK: begin
                if (pr_busy) begin
                    if (pr_ticks != 8'hFF) pr_ticks++;
                    if (pr_ticks >= cfg_timeout) begin
                        pr_busy = 1'b0;
                        pr_count = 0;
                        b.status = ST_TIMEOUT;
                        b.store_index = pr_target;
                        expected_beats.push_back(b);
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void push_item(input logic [1:0] op, input logic [7:0] addr,
                                      input logic [15:0] tgt, input logic [7:0] rxb);
        t_poll_item it;
        it.opcode = op;
        it.addr = addr;
        it.target = tgt;
        it.rx = rxb;
        pending_items.push_back(it);
    endfunction

    // eight-byte reply, optionally with a broken frame byte and ticks spread in
    function automatic void push_reply(input logic [31:0] data_chars, input bit spoil,
                                       input int ticks);
        logic [7:0] frame [REPLY_LEN];
        int         pos;
        int         left;
        left = ticks;
        frame[0] = CHR_R;
        frame[1] = CHR_D;
        frame[2] = CHR_COMMA;
        frame[3] = data_chars[31:24];
        frame[4] = data_chars[23:16];
        frame[5] = data_chars[15:8];
        frame[6] = data_chars[7:0];
        frame[7] = CHR_CR;
        if (spoil) begin
            case ($urandom_range(0, 3))
                0: pos = 0;
                1: pos = 1;
                2: pos = 2;
                default: pos = 7;
            endcase
            frame[pos] = frame[pos] ^ 8'($urandom_range(1, 255));
        end
        for (int k = 0; k < REPLY_LEN; k++) begin
            if (left > 0 && $urandom_range(0, 2) == 0) begin
                push_item(OP_TICK, 8'($urandom), 16'($urandom), 8'($urandom));
                left--;
            end
            push_item(OP_RX, 8'($urandom), 16'($urandom), frame[k]);
        end
    endfunction

    // random hex digit, letters in either case
    function automatic logic [7:0] rand_hex();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10) return CHR_ZERO + 8'(v);
        return ($urandom_range(0, 1) ? "a" : "A") + 8'(v - 10);
    endfunction

    // near-miss characters around the flag patterns
    function automatic logic [7:0] odd_char();
        case ($urandom_range(0, 3))
            0: return CHR_DASH;
            1: return CHR_STAR;
            2: return CHR_ZERO;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] random_data();
        case ($urandom_range(0, 5))
            0: return {4{CHR_DASH}};
            1: return {4{CHR_STAR}};
            2: return {rand_hex(), rand_hex(), CHR_ZERO, CHR_ZERO};
            5: return {odd_char(), odd_char(), odd_char(), odd_char()};
            default: return {rand_hex(), rand_hex(), rand_hex(), rand_hex()};
        endcase
    endfunction

    function automatic logic [15:0] random_target();
        if (cfg_buf_words != 0 && $urandom_range(0, 3) != 0) begin
            return 16'($urandom_range(0, cfg_buf_words - 1));
        end
        return 16'($urandom);
    endfunction

    // one random transaction; returns the number of items it queues, not counting ticks spread into a reply
    function automatic int random_transaction();
        int r;
        int cnt;
        int budget;
        int ticks;
        r = $urandom_range(0, 99);
        // ticks that reach a short timeout, capped for long ones
        ticks = (cfg_timeout == 0) ? 1 : ((cfg_timeout > 8) ? 8 : int'(cfg_timeout));
        if (r < 65) begin
            // full poll, frame sometimes broken, ticks kept under the timeout
            budget = (cfg_timeout > 1) ? $urandom_range(0, (cfg_timeout > 4) ? 3 : cfg_timeout - 1)
                                       : 0;
            push_item(OP_START, 8'($urandom), random_target(), 8'($urandom));
            push_reply(random_data(), $urandom_range(0, 99) < 12, budget);
            return 9;
        end else if (r < 75) begin
            // reply cut short, then abandoned or timed out
            cnt = $urandom_range(1, REPLY_LEN - 1);
            push_item(OP_START, 8'($urandom), random_target(), 8'($urandom));
            for (int k = 0; k < cnt; k++) begin
                push_item(OP_RX, 8'($urandom), 16'($urandom), 8'($urandom));
            end
            if (cfg_timeout <= 8 && $urandom_range(0, 1) == 1) begin
                for (int k = 0; k < ticks; k++) begin
                    push_item(OP_TICK, 8'($urandom), 16'($urandom), 8'($urandom));
                end
                return 1 + cnt + ticks;
            end
            return 1 + cnt;
        end else if (r < 88) begin
            // single noise item of any opcode
            push_item(2'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
            return 1;
        end else begin
            // no reply at all, times out unless the timeout is long
            push_item(OP_START, 8'($urandom), random_target(), 8'($urandom));
            for (int k = 0; k < ticks; k++) begin
                push_item(OP_TICK, 8'($urandom), 16'($urandom), 8'($urandom));
            end
            return 1 + ticks;
        end
    endfunction

    function automatic void random_items(input int count);
        int n;
        n = 0;
        while (n < count) n += random_transaction();
    endfunction

    // clean poll so the block ends a phase idle, then wait for every beat
    task automatic close_phase();
        push_item(OP_START, 8'($urandom), random_target(), 8'($urandom));
        push_reply({rand_hex(), rand_hex(), rand_hex(), rand_hex()}, 1'b0, 0);
        do @(negedge i_clk);
        while (pending_items.size() != 0 || i_valid || expected_beats.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_wen <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
        if (idx == CFG_BUFFER_WORDS) begin
            cfg_buf_words = value;
        end else begin
            cfg_timeout = value[7:0];
        end
    endtask

    // ------------------------------------------------------------------------
    // item driver
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : item_driver
        t_poll_item nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                poller_predict(i_opcode, i_channel_address, i_target_word, i_rx_byte);
            end
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (!quiet && idle_on && $urandom_range(0, 99) < 20) begin
                    send_gap = $urandom_range(0, 4);
                    i_valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    nxt = pending_items.pop_front();
                    i_valid <= 1'b1;
                    i_opcode <= nxt.opcode;
                    i_channel_address <= nxt.addr;
                    i_target_word <= nxt.target;
                    i_rx_byte <= nxt.rx;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // result monitor and stall generator
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : beat_monitor
        t_beat want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_beats.size() == 0) begin
                    report_mismatch($sformatf("beat with none expected: kind %0d tx %h st %0d",
                                              o_kind, o_tx_byte, o_status));
                end else begin
                    want = expected_beats.pop_front();
                    if (o_kind !== want.kind || o_tx_byte !== want.tx ||
                        o_status !== want.status || o_store_valid !== want.store_valid ||
                        o_store_index !== want.store_index ||
                        o_store_value !== want.store_value || o_last !== want.last) begin
                        report_mismatch($sformatf(
                            "got kind %0d tx %h st %0d sv %0d idx %h val %h last %0d, want %0d %h %0d %0d %h %h %0d",
                            o_kind, o_tx_byte, o_status, o_store_valid, o_store_index,
                            o_store_value, o_last, want.kind, want.tx, want.status,
                            want.store_valid, want.store_index, want.store_value, want.last));
                    end
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                i_stall <= 1'b1;
            end else if (!quiet && idle_on && $urandom_range(0, 99) < 20) begin
                recv_gap = $urandom_range(0, 4);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // cycle limit, and stretches with and without idling
    always @(posedge i_clk) begin : watchdog
        cycles <= cycles + 1;
        if ($urandom_range(0, 149) == 0) idle_on <= ~idle_on;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin : test_sequence
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // idle block ignores bytes, ticks and the unused opcode
        push_item(OP_TICK, 8'($urandom), 16'($urandom), 8'($urandom));
        push_item(OP_RX, 8'($urandom), 16'($urandom), 8'($urandom));
        push_item(OP_UNUSED, 8'($urandom), 16'($urandom), 8'($urandom));
        // address wrap to "00", abandoned by a new start at "FF" out of range
        push_item(OP_START, 8'd255, 16'h0000, 8'($urandom));
        push_item(OP_RX, 8'($urandom), 16'($urandom), CHR_R);
        push_item(OP_RX, 8'($urandom), 16'($urandom), CHR_D);
        push_item(OP_RX, 8'($urandom), 16'($urandom), CHR_COMMA);
        push_item(OP_START, 8'd254, 16'hFFFF, 8'($urandom));
        push_reply({4{CHR_DASH}}, 1'b0, 0);
        // station error flag at the lowest index
        push_item(OP_START, 8'd0, 16'h0000, 8'($urandom));
        push_reply({4{CHR_STAR}}, 1'b0, 0);
        // timeout with the reset value
        push_item(OP_START, 8'h5A, 16'd4095, 8'($urandom));
        push_item(OP_TICK, 8'($urandom), 16'($urandom), 8'($urandom));
        push_item(OP_TICK, 8'($urandom), 16'($urandom), 8'($urandom));
        random_items(20);
        close_phase();

        // nothing stored, longest timeout outlasts a few ticks
        write_reg(CFG_BUFFER_WORDS, 16'd0);
        write_reg(CFG_TIMEOUT_TICKS, 16'd255);
        push_item(OP_START, 8'($urandom), 16'($urandom), 8'($urandom));
        push_reply({rand_hex(), rand_hex(), rand_hex(), rand_hex()}, 1'b0, 3);
        random_items(10);
        close_phase();

        // full buffer, one-tick timeout
        write_reg(CFG_BUFFER_WORDS, 16'hFFFF);
        write_reg(CFG_TIMEOUT_TICKS, 16'd1);
        random_items(18);
        close_phase();

        // small buffer, zero timeout
        write_reg(CFG_BUFFER_WORDS, 16'($urandom_range(1, 300)));
        write_reg(CFG_TIMEOUT_TICKS, 16'd0);
        random_items(10);
        close_phase();

        // closing stretch without idling
        write_reg(CFG_BUFFER_WORDS, 16'($urandom));
        write_reg(CFG_TIMEOUT_TICKS, 16'($urandom_range(2, 6)));
        quiet <= 1'b1;
        random_items(20);
        close_phase();

        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
